### sv/magic_framed_packet_deframer_crc16_assert.svh
// Assertion macros used by the checker file.
`ifndef MAGIC_FRAMED_PACKET_DEFRAMER_CRC16_ASSERT_SVH
`define MAGIC_FRAMED_PACKET_DEFRAMER_CRC16_ASSERT_SVH

// Checked only while the block is out of reset.
`define FDC_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Checked at every edge, reset cycles included.
`define FDC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### sv/fdc_pkg.sv
package fdc_pkg;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_HEADER,
        PH_PAYLOAD,
        PH_CRC_HI,
        PH_CRC_LO
    } phase_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_GOOD     = 2'd1,
        KIND_CRC_BAD  = 2'd2,
        KIND_TOO_LONG = 2'd3
    } kind_t;

    localparam int INDEX_W   = 24;
    localparam int MAXLEN_W  = 24;
    localparam int TDATA_W   = 104;
    localparam int FIELD_W   = 4;

    localparam logic [MAXLEN_W-1:0] MAXLEN_RESET = 24'd65536;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_MSB  = 16'h8000;

    localparam logic [7:0] MAGIC_0 = 8'h4B; // 'K'
    localparam logic [7:0] MAGIC_1 = 8'h32; // '2'
    localparam logic [7:0] MAGIC_2 = 8'h33; // '3'
    localparam logic [7:0] MAGIC_3 = 8'h30; // '0'

    localparam logic [FIELD_W-1:0] MAGIC_LEN  = 4'd4;
    localparam logic [FIELD_W-1:0] HDR_LAST   = 4'd8;
    localparam logic [FIELD_W-1:0] SEQ_LAST   = 4'd4;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        kind_t                 kind;
        logic [7:0]            payload_byte;
        logic [INDEX_W-1:0]    byte_index;
        logic [7:0]            frame_type;
        logic [31:0]           seq_num;
        logic [31:0]           payload_length;
        logic                  frame_last;
    } result_t;

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] b;
        unique case (idx)
            2'd0: b = MAGIC_0;
            2'd1: b = MAGIC_1;
            2'd2: b = MAGIC_2;
            default: b = MAGIC_3;
        endcase
        return b;
    endfunction

    // One byte through the CRC-16, most significant bit first.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int b = 0; b < 8; b++) begin
            if ((c & CRC_MSB) != 16'h0000) begin
                c = (c << 1) ^ CRC_POLY;
            end else begin
                c = c << 1;
            end
        end
        return c;
    endfunction

    localparam logic [15:0] CRC_MAGIC =
        crc_feed(crc_feed(crc_feed(crc_feed(CRC_INIT, MAGIC_0), MAGIC_1), MAGIC_2), MAGIC_3);

endpackage

### sv/fdc_front.sv
module fdc_front import fdc_pkg::*; #(
    parameter int COUNT_BITS = 24
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  logic [7:0]          in_byte,
    input  logic [MAXLEN_W-1:0] max_len,
    output logic                push,
    output result_t             push_data
);

    phase_t                 phase_reg, phase_next;
    logic [FIELD_W-1:0]     field_reg, field_next;
    logic [7:0]             type_reg, type_next;
    logic [31:0]            seq_reg, seq_next;
    logic [31:0]            len_reg, len_next;
    logic [COUNT_BITS-1:0]  count_reg, count_next;
    logic [15:0]            crc_reg, crc_next;
    logic [7:0]             crc_hi_reg, crc_hi_next;

    logic [FIELD_W-1:0]     hunt_idx;
    logic [15:0]            crc_upd;
    logic                   too_long;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            field_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            field_reg <= field_next;
        end
        type_reg   <= type_next;
        seq_reg    <= seq_next;
        len_reg    <= len_next;
        count_reg  <= count_next;
        crc_reg    <= crc_next;
        crc_hi_reg <= crc_hi_next;
    end

    assign crc_upd = crc_feed(crc_reg, in_byte);

    always_comb begin
        phase_next  = phase_reg;
        field_next  = field_reg;
        type_next   = type_reg;
        seq_next    = seq_reg;
        len_next    = len_reg;
        count_next  = count_reg;
        crc_next    = crc_reg;
        crc_hi_next = crc_hi_reg;
        hunt_idx    = '0;
        too_long    = 1'b0;
        push        = 1'b0;
        push_data   = '0;

        if (in_valid) begin
            unique case (phase_reg)
                PH_HUNT: begin
                    // A mismatching 'K' still starts a new magic.
                    if (in_byte == magic_byte(field_reg[1:0])) begin
                        hunt_idx = field_reg + 4'd1;
                    end else if (in_byte == MAGIC_0) begin
                        hunt_idx = 4'd1;
                    end else begin
                        hunt_idx = '0;
                    end
                    if (hunt_idx == MAGIC_LEN) begin
                        crc_next   = CRC_MAGIC;
                        phase_next = PH_HEADER;
                        field_next = '0;
                    end else begin
                        field_next = hunt_idx;
                    end
                end
                PH_HEADER: begin
                    crc_next = crc_upd;
                    if (field_reg == '0) begin
                        type_next = in_byte;
                    end else if (field_reg <= SEQ_LAST) begin
                        seq_next = {seq_reg[23:0], in_byte};
                    end else begin
                        len_next = {len_reg[23:0], in_byte};
                    end
                    field_next = field_reg + 4'd1;
                    if (field_reg == HDR_LAST) begin
                        field_next = '0;
                        count_next = '0;
                        too_long   = (len_next > {8'h00, max_len})
                                     || ((len_next >> COUNT_BITS) != 32'd0);
                        if (too_long) begin
                            push                     = 1'b1;
                            push_data.kind           = KIND_TOO_LONG;
                            push_data.frame_type     = type_next;
                            push_data.seq_num        = seq_next;
                            push_data.payload_length = len_next;
                            push_data.frame_last     = 1'b1;
                            phase_next               = PH_HUNT;
                        end else if (len_next == 32'd0) begin
                            phase_next = PH_CRC_HI;
                        end else begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    crc_next                 = crc_upd;
                    push                     = 1'b1;
                    push_data.kind           = KIND_PAYLOAD;
                    push_data.payload_byte   = in_byte;
                    push_data.byte_index     = INDEX_W'(count_reg);
                    push_data.frame_type     = type_reg;
                    push_data.seq_num        = seq_reg;
                    push_data.payload_length = len_reg;
                    push_data.frame_last     = 1'b0;
                    if ((33'(count_reg) + 33'd1) >= {1'b0, len_reg}) begin
                        phase_next = PH_CRC_HI;
                    end
                    count_next = count_reg + COUNT_BITS'(1);
                end
                PH_CRC_HI: begin
                    crc_hi_next = in_byte;
                    phase_next  = PH_CRC_LO;
                end
                PH_CRC_LO: begin
                    push                     = 1'b1;
                    push_data.kind           = ({crc_hi_reg, in_byte} == crc_reg)
                                               ? KIND_GOOD : KIND_CRC_BAD;
                    push_data.frame_type     = type_reg;
                    push_data.seq_num        = seq_reg;
                    push_data.payload_length = len_reg;
                    push_data.frame_last     = 1'b1;
                    phase_next               = PH_HUNT;
                    field_next               = '0;
                end
                default: begin
                    phase_next = PH_HUNT;
                    field_next = '0;
                end
            endcase
        end
    end

endmodule

### sv/fdc_queue.sv
module fdc_queue import fdc_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  result_t push_data,
    output logic    has_room,
    input  logic    pop,
    output logic    out_valid,
    output result_t out_data
);

    result_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]     fill_reg, fill_next;
    logic                do_pop;

    assign has_room  = (fill_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign out_valid = (fill_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign do_pop    = pop && out_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = rd_ptr_reg + QPTR_W'(1);
        end
        priority if (push && !do_pop) begin
            fill_next = fill_reg + (QPTR_W+1)'(1);
        end else if (do_pop && !push) begin
            fill_next = fill_reg - (QPTR_W+1)'(1);
        end else begin
            fill_next = fill_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### sv/magic_framed_packet_deframer_crc16.sv
// A result word is registered into the result queue when its byte is accepted, and is shown
// on the m_axis side once it is at the head of the queue. Throughput: one byte per cycle while
// s_axis_tready is high; s_axis_tready drops only while both result queue entries are held.
// Reset (aresetn low, synchronous): the block hunts for the magic again, the queue is
// emptied, and max_payload_length returns to 65536.
module magic_framed_packet_deframer_crc16 import fdc_pkg::*; #(
    parameter int COUNT_BITS = 24
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,   // rx_byte
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // payload_byte, byte_index, frame_type, sequence number, payload_length
    output logic [TDATA_W-1:0]  m_axis_tdata,
    output logic [1:0]          m_axis_tuser,   // result_kind
    output logic                m_axis_tlast,   // frame_last
    input  logic                cfg_wr_en,
    input  logic [MAXLEN_W-1:0] cfg_wr_data     // max_payload_length
);

    logic [MAXLEN_W-1:0] max_len_reg;
    logic                push;
    result_t             push_data;
    result_t             out_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= MAXLEN_RESET;
        end else if (cfg_wr_en) begin
            max_len_reg <= cfg_wr_data;
        end
    end

    fdc_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid && s_axis_tready),
        .in_byte   (s_axis_tdata),
        .max_len   (max_len_reg),
        .push      (push),
        .push_data (push_data)
    );

    fdc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .has_room  (s_axis_tready),
        .pop       (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (out_data)
    );

    assign m_axis_tdata = {out_data.payload_length, out_data.seq_num, out_data.frame_type,
                           out_data.byte_index, out_data.payload_byte};
    assign m_axis_tuser = out_data.kind;
    assign m_axis_tlast = out_data.frame_last;

endmodule

### sv/fdc_checker.sv
`include "magic_framed_packet_deframer_crc16_assert.svh"

module fdc_checker import fdc_pkg::*; (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_axis_tready,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [TDATA_W-1:0] m_axis_tdata,
    input logic [1:0]         m_axis_tuser,
    input logic               m_axis_tlast
);

    // A stalled result word keeps its contents.
    `FDC_ASSERT(a_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "result word changed while stalled")

    // Frame ends and only frame ends carry tlast.
    `FDC_ASSERT(a_last_kind, aclk, aresetn, m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser != KIND_PAYLOAD)), "tlast does not match result kind")

    // A frame end carries neither a payload byte nor a byte index.
    `FDC_ASSERT(a_end_zero, aclk, aresetn, m_axis_tvalid && m_axis_tlast |-> (m_axis_tdata[31:0] == 32'd0), "frame end carries payload data")

    // Reset leaves an empty queue with room for input.
    `FDC_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_axis_tvalid && s_axis_tready, "queue not empty after reset")

endmodule

bind magic_framed_packet_deframer_crc16 fdc_checker u_fdc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
